// ===== sv/sxiv_pkg.sv =====
// ----------------------------------------------------------------------------
// sxiv_pkg
// Shared types, constants and opcode tables for the SIC/XE instruction
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package sxiv_pkg;

  // Field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned StatusW = 5;
  localparam int unsigned FmtW    = 2;
  localparam int unsigned InDataW  = 40;  // 36 payload bits padded to bytes
  localparam int unsigned OutDataW = 8;   // 7 payload bits padded to bytes

  // Opcodes with special handling (byte 0, ni bits included where relevant)
  localparam logic [7:0] OpRsub    = 8'h4C;
  localparam logic [7:0] OpRsubNi  = 8'h4F;
  localparam logic [7:0] OpShiftL  = 8'hA4;
  localparam logic [7:0] OpShiftR  = 8'hA8;
  localparam logic [7:0] OpSvc     = 8'hB0;
  localparam logic [7:0] OpClear   = 8'hB4;
  localparam logic [7:0] OpTixr    = 8'hB8;

  // Format class codes
  localparam logic [FmtW-1:0] FmtNone = 2'd0;
  localparam logic [FmtW-1:0] Fmt1    = 2'd1;
  localparam logic [FmtW-1:0] Fmt2    = 2'd2;
  localparam logic [FmtW-1:0] Fmt34   = 2'd3;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK           = 5'd0,
    ST_BAD_LEN      = 5'd1,
    ST_NOT_SIC      = 5'd2,
    ST_RSUB_OPND    = 5'd3,
    ST_SIC_4BYTE    = 5'd4,
    ST_NOT_XE       = 5'd5,
    ST_RSUB_NI      = 5'd6,
    ST_F1_LEN       = 5'd7,
    ST_F2_LEN       = 5'd8,
    ST_F2_NI        = 5'd9,
    ST_BAD_REG      = 5'd10,
    ST_FLOAT_REG    = 5'd11,
    ST_R2_NONZERO   = 5'd12,
    ST_F34_LEN      = 5'd13,
    ST_X_NO_NI      = 5'd14,
    ST_E_CLR_4BYTE  = 5'd15,
    ST_E_SET_3BYTE  = 5'd16,
    ST_E_WITH_BP    = 5'd17,
    ST_B_AND_P      = 5'd18
  } status_e;

  // One decoded result
  typedef struct packed {
    status_e         status;
    logic [FmtW-1:0] fmt;
  } res_t;

  // Plain SIC opcode set, bit k set when opcode k*4 is a SIC opcode
  localparam logic [63:0] SicMask = 64'h05C0_0000_003F_FFFF;

  // Table format of an opcode (byte 0 >> 2)
  function automatic logic [FmtW-1:0] xe_format(input logic [5:0] idx);
    logic [FmtW-1:0] f;
    f = FmtNone;
    if (idx <= 6'd34)                      f = Fmt34;
    else if (idx >= 6'd36 && idx <= 6'd46) f = Fmt2;
    else if (idx >= 6'd48 && idx <= 6'd50) f = Fmt1;
    else if (idx >= 6'd52 && idx <= 6'd56) f = Fmt34;
    else if (idx == 6'd58 || idx == 6'd59) f = Fmt34;
    else if (idx >= 6'd60 && idx <= 6'd62) f = Fmt1;
    return f;
  endfunction

  // Register number 7 or above 9 is not a register
  function automatic logic bad_reg4(input logic [3:0] r);
    return (r > 4'd9) || (r == 4'd7);
  endfunction

  function automatic logic bad_reg8(input logic [7:0] r);
    return (r > 8'd9) || (r == 8'd7);
  endfunction

endpackage : sxiv_pkg

`default_nettype wire

// ===== sv/sxiv_decode.sv =====
// ----------------------------------------------------------------------------
// sxiv_decode
// Combinational legality check of one registered instruction: length, opcode
// tables, format-2 register fields and format-3/4 flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sxiv_decode (
  input  wire logic [sxiv_pkg::WordW-1:0]  word_i,
  input  wire logic [sxiv_pkg::CountW-1:0] count_i,
  output sxiv_pkg::res_t                   res_o
);
  import sxiv_pkg::*;

  logic [7:0]      op, b1, b2, base;
  logic [1:0]      ni;
  logic [2:0]      nbytes;
  logic            bad_len, rsub_zero, in_sic;
  logic [FmtW-1:0] fmt;
  logic [3:0]      r1, r2;
  logic            fx, fb, fp, fe;
  status_e         st;

  // Field split
  assign op     = word_i[31:24];
  assign b1     = word_i[23:16];
  assign b2     = word_i[15:8];
  assign base   = {op[7:2], 2'b00};
  assign ni     = op[1:0];
  assign nbytes = count_i[3:1];
  assign r1     = b1[7:4];
  assign r2     = b1[3:0];
  assign fx     = b1[7];
  assign fb     = b1[6];
  assign fp     = b1[5];
  assign fe     = b1[4];

  assign bad_len   = (count_i == '0) || count_i[0] || (count_i > 4'd8);
  assign rsub_zero = (nbytes >= 3'd3) && (b1 == 8'h00) && (b2 == 8'h00);
  assign in_sic    = SicMask[op[7:2]];
  assign fmt       = xe_format(op[7:2]);

  // Priority chain of checks
  always_comb begin
    st = ST_OK;
    if (bad_len) begin
      st = ST_BAD_LEN;
    end else if (ni == 2'b00 && nbytes == 3'd3) begin
      if (!in_sic)                          st = ST_NOT_SIC;
      else if (op == OpRsub && !rsub_zero)  st = ST_RSUB_OPND;
    end else if (ni == 2'b00 && nbytes == 3'd4) begin
      st = ST_SIC_4BYTE;
    end else if (fmt == FmtNone) begin
      st = ST_NOT_XE;
    end else if (op == OpRsubNi && !rsub_zero) begin
      st = ST_RSUB_OPND;
    end else if (base == OpRsub && op != OpRsubNi) begin
      st = ST_RSUB_NI;
    end else if (fmt == Fmt1) begin
      if (nbytes != 3'd1) st = ST_F1_LEN;
    end else if (fmt == Fmt2) begin
      if (nbytes != 3'd2)                               st = ST_F2_LEN;
      else if (ni != 2'b00)                             st = ST_F2_NI;
      else if (base == OpSvc)                           st = ST_OK;
      else if (base == OpShiftL || base == OpShiftR) begin
        // shift byte checked whole
        if (bad_reg8(b1))       st = ST_BAD_REG;
        else if (b1 == 8'd6)    st = ST_FLOAT_REG;
      end
      else if ((base == OpClear || base == OpTixr) && r2 != 4'd0)
        st = ST_R2_NONZERO;
      else if (bad_reg4(r1) || bad_reg4(r2))            st = ST_BAD_REG;
      else if (r1 == 4'd6 || r2 == 4'd6)                st = ST_FLOAT_REG;
    end else begin
      // format 3/4 flag checks
      if (nbytes != 3'd3 && nbytes != 3'd4)  st = ST_F34_LEN;
      else if (fx && ni != 2'b11)            st = ST_X_NO_NI;
      else if (!fe && nbytes == 3'd4)        st = ST_E_CLR_4BYTE;
      else if (fe && nbytes == 3'd3)         st = ST_E_SET_3BYTE;
      else if (fe && (fb || fp))             st = ST_E_WITH_BP;
      else if (fb && fp)                     st = ST_B_AND_P;
    end
  end

  assign res_o.status = st;
  assign res_o.fmt    = bad_len ? FmtNone : fmt;

endmodule : sxiv_decode

`default_nettype wire

// ===== sv/sicxe_instruction_validator_core.sv =====
// ----------------------------------------------------------------------------
// sicxe_instruction_validator_core
// Stream block that checks one SIC/XE instruction per item and returns its
// legality status and table format class.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one item carries a left-aligned instruction word
//   (up to four bytes) and its length in hex digits. Output channel m_axis:
//   one item per input item, carrying the status code (0 = legal, 1..18 =
//   the failing check) and the opcode's format class (0, 1, 2 or 3 for 3/4).
//   An accepted item goes into an input register, which feeds the decode
//   logic, which feeds the result register.
//   Throughput is one item per cycle while m_axis_tready stays high; when a
//   result waits, the input register still takes a new item if it is empty.
//   When m_axis_tready is low the result register holds, the input register
//   fills, and s_axis_tready drops until the receiver takes the result.
//   Reset (rst_ni low, asynchronous) empties both stages; no item is
//   invented across it. There is no configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sicxe_instruction_validator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] instruction_word, [35:32] digit_count, [39:36] zero
  input  wire logic [sxiv_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [4:0] status, [6:5] format_class, [7] zero
  output logic [sxiv_pkg::OutDataW-1:0]       m_axis_tdata
);
  import sxiv_pkg::*;

  logic              in_v_q;
  logic [WordW-1:0]  word_q;
  logic [CountW-1:0] count_q;
  logic              out_v_q;
  res_t              res_q, res_d;
  logic              out_load, in_load;

  // Handshake: each stage loads when the one ahead can take its contents
  assign out_load      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      word_q  <= s_axis_tdata[WordW-1:0];
      count_q <= s_axis_tdata[WordW+CountW-1:WordW];
    end
  end

  // Decode logic
  sxiv_decode u_decode (
    .word_i  (word_q),
    .count_i (count_q),
    .res_o   (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_v_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, res_q.fmt, res_q.status};

endmodule : sicxe_instruction_validator_core

`default_nettype wire
